// ----- rtl/slt_pkg.sv -----
`timescale 1ns / 1ps

package slt_pkg;

  // Request operation codes
  localparam logic [2:0] OP_APPEND        = 3'd0;
  localparam logic [2:0] OP_REMOVE_LAST   = 3'd1;
  localparam logic [2:0] OP_REMOVE_AT     = 3'd2;
  localparam logic [2:0] OP_SEARCH        = 3'd3;
  localparam logic [2:0] OP_SEARCH_REMOVE = 3'd4;

  // Microprogram step addresses
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_APP    = 4'd1;
  localparam logic [3:0] S_APPW   = 4'd2;
  localparam logic [3:0] S_RML    = 4'd3;
  localparam logic [3:0] S_RMA    = 4'd4;
  localparam logic [3:0] S_SRCH   = 4'd5;
  localparam logic [3:0] S_CMP    = 4'd6;
  localparam logic [3:0] S_HIT    = 4'd7;
  localparam logic [3:0] S_SHRD   = 4'd8;
  localparam logic [3:0] S_SHWR   = 4'd9;
  localparam logic [3:0] S_DEC    = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  // Branch condition codes
  localparam logic [2:0] C_NEVER  = 3'd0;
  localparam logic [2:0] C_FULL   = 3'd1;
  localparam logic [2:0] C_EMPTY  = 3'd2;
  localparam logic [2:0] C_POSBAD = 3'd3;
  localparam logic [2:0] C_MATCH  = 3'd4;
  localparam logic [2:0] C_OPSR   = 3'd5;
  localparam logic [2:0] C_MORE1  = 3'd6;
  localparam logic [2:0] C_MORE2  = 3'd7;

  // Read address select
  localparam logic [1:0] RD_ZERO = 2'd0;
  localparam logic [1:0] RD_IDX1 = 2'd1;
  localparam logic [1:0] RD_IDX2 = 2'd2;

  // Write select
  localparam logic [1:0] WR_NONE   = 2'd0;
  localparam logic [1:0] WR_APPEND = 2'd1;
  localparam logic [1:0] WR_SHIFT  = 2'd2;

  // Index register operation
  localparam logic [1:0] IX_HOLD = 2'd0;
  localparam logic [1:0] IX_ZERO = 2'd1;
  localparam logic [1:0] IX_POS  = 2'd2;
  localparam logic [1:0] IX_INC  = 2'd3;

  // Count register operation
  localparam logic [1:0] CN_HOLD = 2'd0;
  localparam logic [1:0] CN_INC  = 2'd1;
  localparam logic [1:0] CN_DEC  = 2'd2;

  typedef struct packed {
    logic [2:0]        op;
    logic signed [31:0] item_value;
    logic [6:0]        item_position;
  } request_t;

  typedef struct packed {
    logic       success;
    logic [6:0] found_position;
    logic [7:0] count_after;
  } result_t;

  // One control word: branch if cond, else stay if loopc, else go to jf
  typedef struct packed {
    logic       dispatch;
    logic [2:0] cond;
    logic [3:0] jt;
    logic [2:0] loopc;
    logic [3:0] jf;
    logic [1:0] rd_sel;
    logic [1:0] wr_sel;
    logic [1:0] idx_op;
    logic [1:0] cnt_op;
    logic       set_succ;
    logic       set_where;
    logic       done;
  } uword_t;

  // Control store
  function automatic uword_t ucode(input logic [3:0] step);
    uword_t w;
    w = '0;
    w.jf = S_IDLE;
    unique case (step)
      S_IDLE: begin
        w.dispatch = 1'b1;
      end
      S_APP: begin
        w.cond = C_FULL;
        w.jt   = S_DONE;
        w.jf   = S_APPW;
      end
      S_APPW: begin
        w.wr_sel   = WR_APPEND;
        w.cnt_op   = CN_INC;
        w.set_succ = 1'b1;
        w.jf       = S_DONE;
      end
      S_RML: begin
        w.cond = C_EMPTY;
        w.jt   = S_DONE;
        w.jf   = S_DEC;
      end
      S_RMA: begin
        w.cond   = C_POSBAD;
        w.jt     = S_DONE;
        w.jf     = S_SHRD;
        w.idx_op = IX_POS;
      end
      S_SRCH: begin
        w.cond   = C_EMPTY;
        w.jt     = S_DONE;
        w.jf     = S_CMP;
        w.idx_op = IX_ZERO;
        w.rd_sel = RD_ZERO;
      end
      S_CMP: begin
        w.cond   = C_MATCH;
        w.jt     = S_HIT;
        w.loopc  = C_MORE1;
        w.jf     = S_DONE;
        w.rd_sel = RD_IDX1;
        w.idx_op = IX_INC;
      end
      S_HIT: begin
        w.set_succ  = 1'b1;
        w.set_where = 1'b1;
        w.cond      = C_OPSR;
        w.jt        = S_SHRD;
        w.jf        = S_DONE;
      end
      S_SHRD: begin
        w.rd_sel = RD_IDX1;
        w.cond   = C_MORE1;
        w.jt     = S_SHWR;
        w.jf     = S_DEC;
      end
      S_SHWR: begin
        w.wr_sel = WR_SHIFT;
        w.rd_sel = RD_IDX2;
        w.idx_op = IX_INC;
        w.loopc  = C_MORE2;
        w.jf     = S_DEC;
      end
      S_DEC: begin
        w.cnt_op   = CN_DEC;
        w.set_succ = 1'b1;
        w.jf       = S_DONE;
      end
      S_DONE: begin
        w.done = 1'b1;
        w.jf   = S_IDLE;
      end
      default: begin
        w.jf = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/slt_ram.sv -----
`timescale 1ns / 1ps

module slt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/sequential_list_table.sv -----
`timescale 1ns / 1ps

// Packed list of signed 32-bit values with an entry count. A request is taken
// when start is high and busy is low; its single result appears on result for
// exactly one cycle with done high, and must be taken then since the block
// cannot be held off. Search, remove-at and search-and-remove walk the list
// one entry per cycle through the single read port of the list memory. No
// new request is taken until the result has been shown. The memory needs no
// clearing after reset: only entries below the count are ever used.
module sequential_list_table #(
  parameter int DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  slt_pkg::request_t request,
  output logic              done,
  output slt_pkg::result_t  result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [3:0]         pc;
  logic [3:0]         pc_next;
  slt_pkg::request_t  req;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      idx;
  logic [AW-1:0]      where;
  logic               succ;
  slt_pkg::uword_t    w;
  logic [7:0]         flags;
  logic               taken;
  logic               accept;
  logic [CW:0]        idx1;
  logic [CW:0]        idx2;
  logic [CW+6:0]      pos_wide;
  logic [CW+6:0]      cnt_pos;
  logic [CW+7:0]      cnt_wide;
  logic [AW+6:0]      where_wide;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [31:0]        wr_data;
  logic [AW-1:0]      rd_addr;
  logic [31:0]        rd_data;

  assign w      = slt_pkg::ucode(pc);
  assign busy   = (pc != slt_pkg::S_IDLE);
  assign accept = start && !busy;

  assign idx1     = {1'b0, idx} + {{CW{1'b0}}, 1'b1};
  assign idx2     = {1'b0, idx} + {{(CW-1){1'b0}}, 2'd2};
  assign pos_wide = {{CW{1'b0}}, req.item_position};
  assign cnt_pos  = {7'd0, cnt};

  // Branch conditions, indexed by condition code
  always_comb begin
    flags                    = '0;
    flags[slt_pkg::C_NEVER]  = 1'b0;
    flags[slt_pkg::C_FULL]   = (cnt == CW'(DEPTH));
    flags[slt_pkg::C_EMPTY]  = (cnt == '0);
    flags[slt_pkg::C_POSBAD] = (pos_wide >= cnt_pos);
    flags[slt_pkg::C_MATCH]  = (rd_data == $unsigned(req.item_value));
    flags[slt_pkg::C_OPSR]   = (req.op == slt_pkg::OP_SEARCH_REMOVE);
    flags[slt_pkg::C_MORE1]  = (idx1 < {1'b0, cnt});
    flags[slt_pkg::C_MORE2]  = (idx2 < {1'b0, cnt});
  end

  assign taken = flags[w.cond];

  // Sequence the step counter: dispatch on op, else branch, loop or fall on
  always_comb begin
    pc_next = pc;
    if (w.dispatch) begin
      if (accept) begin
        unique case (request.op)
          slt_pkg::OP_APPEND:        pc_next = slt_pkg::S_APP;
          slt_pkg::OP_REMOVE_LAST:   pc_next = slt_pkg::S_RML;
          slt_pkg::OP_REMOVE_AT:     pc_next = slt_pkg::S_RMA;
          slt_pkg::OP_SEARCH,
          slt_pkg::OP_SEARCH_REMOVE: pc_next = slt_pkg::S_SRCH;
          default:                   pc_next = slt_pkg::S_DONE;
        endcase
      end
    end else if (taken) begin
      pc_next = w.jt;
    end else if (flags[w.loopc]) begin
      pc_next = pc;
    end else begin
      pc_next = w.jf;
    end
  end

  // Advance control state and the count
  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= slt_pkg::S_IDLE;
      cnt  <= '0;
      succ <= 1'b0;
    end else begin
      pc <= pc_next;
      unique case (w.cnt_op)
        slt_pkg::CN_INC: cnt <= cnt + CW'(1);
        slt_pkg::CN_DEC: cnt <= cnt - CW'(1);
        default:         cnt <= cnt;
      endcase
      if (accept) begin
        succ <= 1'b0;
      end else if (w.set_succ) begin
        succ <= 1'b1;
      end
    end
  end

  // Hold the request, walk the index, capture the match position
  always_ff @(posedge clk) begin
    if (accept) begin
      req   <= request;
      where <= '0;
    end else if (w.set_where) begin
      where <= idx[AW-1:0];
    end
    unique case (w.idx_op)
      slt_pkg::IX_ZERO: idx <= '0;
      slt_pkg::IX_POS:  idx <= pos_wide[CW-1:0];
      slt_pkg::IX_INC:  if (!taken) idx <= idx1[CW-1:0];
      default:          idx <= idx;
    endcase
  end

  // Memory port selection
  always_comb begin
    unique case (w.rd_sel)
      slt_pkg::RD_IDX1: rd_addr = idx1[AW-1:0];
      slt_pkg::RD_IDX2: rd_addr = idx2[AW-1:0];
      default:          rd_addr = '0;
    endcase
  end

  assign wr_en   = (w.wr_sel != slt_pkg::WR_NONE);
  assign wr_addr = (w.wr_sel == slt_pkg::WR_APPEND) ? cnt[AW-1:0] : idx[AW-1:0];
  assign wr_data = (w.wr_sel == slt_pkg::WR_APPEND) ? $unsigned(req.item_value) : rd_data;

  slt_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Drive the result
  assign cnt_wide   = {8'd0, cnt};
  assign where_wide = {7'd0, where};

  assign done                  = w.done;
  assign result.success        = succ;
  assign result.found_position = where_wide[6:0];
  assign result.count_after    = cnt_wide[7:0];

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("transfer taken but block not busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("block still busy after result");

  a_append_inc: assert property (@(posedge clk) disable iff (rst)
    (pc == slt_pkg::S_APPW) |=> (cnt == $past(cnt) + CW'(1)))
    else $error("append did not raise count");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    (w.wr_sel == slt_pkg::WR_SHIFT) |-> (idx1 < {1'b0, cnt}))
    else $error("shift write beyond held entries");

endmodule

// ----- tb/sequential_list_table_test.sv -----
`timescale 1ns / 1ps

module sequential_list_table_test;

  localparam int DEPTH = 128;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int PHASE_ITEMS = 210;
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID = 3'd6;
  localparam logic [2:0] OP_UNUSED_LAST = 3'd7;

  // Shadow copy of the list: predicts each result and holds those still owed
  class list_tracker;
    logic signed [31:0] entries [DEPTH];
    int unsigned fill;
    int unsigned peak;
    slt_pkg::result_t awaited [$];
    int unsigned errors;
    int unsigned requests;
    int unsigned hits;
    int unsigned refusals;

    function new();
      fill = 0;
      peak = 0;
      errors = 0;
      requests = 0;
      hits = 0;
      refusals = 0;
    endfunction

    // Drop one entry and move every later entry down by one
    function void close_gap(int unsigned at);
      int unsigned k;
      for (k = at; k + 1 < fill; k++)
        entries[k] = entries[k + 1];
      fill--;
    endfunction

    // Apply one accepted transfer and queue the result it must produce
    function void note_request(slt_pkg::request_t req);
      slt_pkg::result_t res;
      bit ok;
      int unsigned at;
      int unsigned k;
      ok = 1'b0;
      at = 0;
      case (req.op)
        slt_pkg::OP_APPEND: begin
          if (fill < DEPTH) begin
            entries[fill] = req.item_value;
            fill++;
            ok = 1'b1;
          end
        end
        slt_pkg::OP_REMOVE_LAST: begin
          if (fill > 0) begin
            fill--;
            ok = 1'b1;
          end
        end
        slt_pkg::OP_REMOVE_AT: begin
          if (req.item_position < fill) begin
            close_gap(req.item_position);
            ok = 1'b1;
          end
        end
        slt_pkg::OP_SEARCH, slt_pkg::OP_SEARCH_REMOVE: begin
          for (k = 0; k < fill && !ok; k++) begin
            if (entries[k] == req.item_value) begin
              ok = 1'b1;
              at = k;
            end
          end
          if (ok) hits++;
          if (ok && req.op == slt_pkg::OP_SEARCH_REMOVE) close_gap(at);
        end
        default: begin
        end
      endcase
      if (!ok) refusals++;
      if (fill > peak) peak = fill;
      requests++;
      res.success = ok;
      res.found_position = 7'(at);
      res.count_after = 8'(fill);
      awaited.push_back(res);
    endfunction

    // Compare one result, field by field, with the oldest expectation
    function void check_result(slt_pkg::result_t got);
      slt_pkg::result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding: success %0d position %0d count %0d",
                 $time, got.success, got.found_position, got.count_after);
        return;
      end
      want = awaited.pop_front();
      if (got.success !== want.success) begin
        errors++;
        $display("%0t: success mismatch, expected %0d, actual %0d",
                 $time, want.success, got.success);
      end
      if (got.found_position !== want.found_position) begin
        errors++;
        $display("%0t: found_position mismatch, expected %0d, actual %0d",
                 $time, want.found_position, got.found_position);
      end
      if (got.count_after !== want.count_after) begin
        errors++;
        $display("%0t: count_after mismatch, expected %0d, actual %0d",
                 $time, want.count_after, got.count_after);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  slt_pkg::request_t request = '0;
  logic busy;
  logic done;
  slt_pkg::result_t result;
  int unsigned cycle_count = 0;
  list_tracker tracker = new();

  sequential_list_table #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  always #2 clk = ~clk;

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // Check results and record accepted transfers at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) tracker.check_result(result);
      if (start && !busy) tracker.note_request(request);
    end
  end

  function automatic slt_pkg::request_t make(logic [2:0] op, logic signed [31:0] value,
                                             logic [6:0] position);
    slt_pkg::request_t r;
    r.op = op;
    r.item_value = value;
    r.item_position = position;
    return r;
  endfunction

  // Favour values already held, and a narrow range so duplicates occur
  function automatic logic signed [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40 && tracker.fill > 0)
      return tracker.entries[$urandom_range(tracker.fill - 1)];
    if (roll < 65)
      return $signed(32'($urandom_range(8))) - 32'sd4;
    return $signed($urandom);
  endfunction

  function automatic logic [6:0] pick_position();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60 && tracker.fill > 0)
      return 7'($urandom_range(tracker.fill - 1));
    if (roll < 75)
      return (tracker.fill > 127) ? 7'd127 : 7'(tracker.fill);
    return 7'($urandom_range(127));
  endfunction

  // Growing phases lean on append; shrinking phases lean on the removals
  function automatic slt_pkg::request_t random_request(bit growing);
    int unsigned roll;
    logic [2:0] op;
    roll = $urandom_range(99);
    if (growing) begin
      if (roll < 80) op = slt_pkg::OP_APPEND;
      else if (roll < 84) op = slt_pkg::OP_REMOVE_LAST;
      else if (roll < 89) op = slt_pkg::OP_REMOVE_AT;
      else if (roll < 93) op = slt_pkg::OP_SEARCH;
      else if (roll < 97) op = slt_pkg::OP_SEARCH_REMOVE;
      else op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    end else begin
      if (roll < 5) op = slt_pkg::OP_APPEND;
      else if (roll < 45) op = slt_pkg::OP_REMOVE_LAST;
      else if (roll < 70) op = slt_pkg::OP_REMOVE_AT;
      else if (roll < 80) op = slt_pkg::OP_SEARCH;
      else if (roll < 97) op = slt_pkg::OP_SEARCH_REMOVE;
      else op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    end
    return make(op, pick_value(), pick_position());
  endfunction

  // Present one transfer and hold it until the block takes it
  task automatic send(slt_pkg::request_t r);
    @(negedge clk);
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(int unsigned cycles);
    int unsigned n;
    @(negedge clk);
    start <= 1'b0;
    for (n = 1; n < cycles; n++) @(negedge clk);
  endtask

  // Stop sending until every outstanding result has been seen
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.awaited.size() != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned i;
    bit calm;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty list refusals and unused codes
    send(make(slt_pkg::OP_REMOVE_LAST, 32'sd0, 7'd0));
    send(make(slt_pkg::OP_SEARCH, 32'sd0, 7'd0));
    send(make(slt_pkg::OP_SEARCH_REMOVE, 32'sd0, 7'd0));
    send(make(slt_pkg::OP_REMOVE_AT, 32'sd0, 7'd0));
    send(make(OP_UNUSED_FIRST, 32'sd0, 7'd127));
    send(make(OP_UNUSED_MID, -32'sd1, 7'd0));
    send(make(OP_UNUSED_LAST, 32'sh7fffffff, 7'd127));
    // Extreme values, with a duplicate to check first-match order
    send(make(slt_pkg::OP_APPEND, 32'sh7fffffff, 7'd127));
    send(make(slt_pkg::OP_APPEND, 32'sh80000000, 7'd0));
    send(make(slt_pkg::OP_APPEND, 32'sd0, 7'd127));
    send(make(slt_pkg::OP_APPEND, -32'sd1, 7'd0));
    send(make(slt_pkg::OP_APPEND, 32'sh80000000, 7'd0));
    send(make(slt_pkg::OP_SEARCH, 32'sh80000000, 7'd0));
    send(make(slt_pkg::OP_SEARCH, -32'sd1, 7'd0));
    send(make(slt_pkg::OP_SEARCH, 32'sd12345, 7'd0));
    send(make(slt_pkg::OP_SEARCH_REMOVE, 32'sh80000000, 7'd0));
    send(make(slt_pkg::OP_SEARCH, 32'sh80000000, 7'd0));
    // Positions at and beyond the count, then the head
    send(make(slt_pkg::OP_REMOVE_AT, 32'sd0, 7'd127));
    send(make(slt_pkg::OP_REMOVE_AT, 32'sd0, 7'd4));
    send(make(slt_pkg::OP_REMOVE_AT, 32'sd0, 7'd0));
    send(make(slt_pkg::OP_SEARCH_REMOVE, 32'sd55, 7'd0));
    send(make(slt_pkg::OP_REMOVE_LAST, 32'sd0, 7'd0));
    send(make(OP_UNUSED_FIRST, 32'sd0, 7'd0));
    settle();

    // Alternate filling and draining, with a calm stretch and some full pauses
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 420 && i < 630);
      if (!calm && $urandom_range(99) < 20) hold_off($urandom_range(1, 8));
      send(random_request(((i / PHASE_ITEMS) % 2) == 0));
      if (i % 300 == 299) settle();
    end
    settle();
    repeat (DEPTH + 10) @(posedge clk);

    $display("Ran %0d requests through fill and drain phases: %0d search hits, %0d refusals,",
             tracker.requests, tracker.hits, tracker.refusals);
    $display("list peaked at %0d of %0d entries", tracker.peak, DEPTH);
    if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing", tracker.errors, tracker.awaited.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
